// ===== hdl/sfdp_pkg.sv =====
// shared types, constants and helpers for the stereo feedback delay
`timescale 1ns / 1ps

package sfdp_pkg;

	localparam int DEPTH_DEF = 16384;
	localparam int SAMPLE_W  = 16;
	localparam int LEN_W     = 14;
	localparam int GAIN_W    = 16;
	localparam int IDX_W     = 2;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_DELAY    = 2'd0,
		REG_MIX      = 2'd1,
		REG_FEEDBACK = 2'd2,
		REG_PAN      = 2'd3
	} reg_idx_t;

	// where the delayed sample of an item comes from
	typedef enum logic [1:0] {
		SRC_ZERO  = 2'd0,
		SRC_STORE = 2'd1,
		SRC_SELF  = 2'd2
	} src_kind_t;

	typedef struct packed {
		src_kind_t           kind;
		logic [SAMPLE_W-1:0] right;
		logic [SAMPLE_W-1:0] left;
	} item_t;

	typedef struct packed {
		logic                busy;
		logic [LEN_W-1:0]    len;
		logic [31:0]         gain_l;
		logic [31:0]         gain_r;
		logic [GAIN_W-1:0]   fb;
	} cfg_t;

	function automatic logic [SAMPLE_W-1:0] sat16(input logic signed [17:0] v);
		logic [SAMPLE_W-1:0] r;
		if (v > 18'sd32767) begin
			r = 16'h7fff;
		end else if (v < -18'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/sfdp_cfg.sv =====
// configuration registers, delay length reduction and wet gain products
`timescale 1ns / 1ps

module sfdp_cfg #(
	parameter int DELAY_DEPTH = sfdp_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sfdp_pkg::IDX_W-1:0]    cfg_index,
	input  logic [15:0]                   cfg_data,
	output sfdp_pkg::cfg_t                cfg
);

	localparam int LEN_W   = sfdp_pkg::LEN_W;
	localparam int DEP_W   = $clog2(DELAY_DEPTH);
	localparam int SH      = LEN_W + DEP_W;
	localparam int RECIP_W = LEN_W + 2;
	// rounded-up reciprocal, exact quotient for every length that fits LEN_W
	localparam longint RECIP = ((longint'(1) << SH) + longint'(DELAY_DEPTH) - 1)
		/ longint'(DELAY_DEPTH);

	logic [LEN_W-1:0]  rem_q;
	logic [LEN_W-1:0]  raw_q;
	logic [LEN_W-1:0]  quo_q;
	logic              phase_q;
	logic              busy_q;
	logic [15:0]       mix_q;
	logic [15:0]       fb_q;
	logic [15:0]       pan_q;
	logic [31:0]       gain_l_q;
	logic [31:0]       gain_r_q;
	logic              wr;
	logic              len_wr;
	logic [16:0]       weight_l;
	logic [LEN_W+RECIP_W-1:0] prod;
	logic [LEN_W-1:0]  mult_c;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;
	assign len_wr = wr && (sfdp_pkg::reg_idx_t'(cfg_index) == sfdp_pkg::REG_DELAY);
	assign weight_l = 17'h10000 - {1'b0, pan_q};
	assign prod = {{RECIP_W{1'b0}}, raw_q} * {{LEN_W{1'b0}}, RECIP_W'(RECIP)};
	assign mult_c = LEN_W'(32'(quo_q) * 32'(DELAY_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= '0;
			raw_q    <= '0;
			quo_q    <= '0;
			phase_q  <= 1'b0;
			busy_q   <= 1'b0;
			mix_q    <= '0;
			fb_q     <= '0;
			pan_q    <= 16'h8000;
			gain_l_q <= '0;
			gain_r_q <= '0;
		end else begin
			gain_l_q <= {16'b0, mix_q} * {15'b0, weight_l};
			gain_r_q <= {16'b0, mix_q} * {16'b0, pan_q};
			if (len_wr) begin
				raw_q   <= cfg_data[LEN_W-1:0];
				phase_q <= 1'b1;
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				// quotient first, then the remainder
				if (phase_q) begin
					quo_q   <= LEN_W'(prod >> SH);
					phase_q <= 1'b0;
				end else begin
					rem_q  <= raw_q - mult_c;
					busy_q <= 1'b0;
				end
			end
			if (wr) begin
				case (sfdp_pkg::reg_idx_t'(cfg_index))
					sfdp_pkg::REG_MIX:      mix_q <= cfg_data;
					sfdp_pkg::REG_FEEDBACK: fb_q  <= cfg_data;
					sfdp_pkg::REG_PAN:      pan_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		cfg.busy   = busy_q;
		cfg.len    = rem_q;
		cfg.gain_l = gain_l_q;
		cfg.gain_r = gain_r_q;
		cfg.fb     = fb_q;
	end

endmodule

// ===== hdl/sfdp_front.sv =====
// input side: accepts sample pairs, tracks the write pointer, works out the read index
`timescale 1ns / 1ps

module sfdp_front #(
	parameter int DELAY_DEPTH = sfdp_pkg::DEPTH_DEF,
	parameter int PTR_W       = $clog2(DELAY_DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,
	input  sfdp_pkg::cfg_t        cfg,
	input  logic                  q_full,
	output logic                  push,
	output sfdp_pkg::item_t       item,
	output logic [PTR_W-1:0]      wr_ptr,
	output logic [PTR_W-1:0]      rd_ptr
);

	localparam int CW = ((PTR_W > sfdp_pkg::LEN_W) ? PTR_W : sfdp_pkg::LEN_W) + 1;
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DELAY_DEPTH - 1);

	logic [PTR_W-1:0] wp_q;
	logic             wrapped_q;
	logic [CW-1:0]    next_c;
	logic [CW-1:0]    len_c;
	logic [CW-1:0]    rd_full;

	assign s_tready = !cfg.busy && !q_full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		next_c  = (wp_q == LAST) ? '0 : CW'(wp_q) + CW'(1);
		len_c   = CW'(cfg.len);
		rd_full = (next_c >= len_c) ? next_c - len_c : next_c + CW'(DELAY_DEPTH) - len_c;
		rd_ptr  = rd_full[PTR_W-1:0];
		wr_ptr  = wp_q;
		item.left  = s_tdata[15:0];
		item.right = s_tdata[31:16];
		// entries behind the pointer have been written since reset
		if (rd_ptr == wp_q) begin
			item.kind = sfdp_pkg::SRC_SELF;
		end else if (wrapped_q || rd_ptr < wp_q) begin
			item.kind = sfdp_pkg::SRC_STORE;
		end else begin
			item.kind = sfdp_pkg::SRC_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
		end else if (push) begin
			if (wp_q == LAST) begin
				wp_q      <= '0;
				wrapped_q <= 1'b1;
			end else begin
				wp_q <= wp_q + PTR_W'(1);
			end
		end
	end

endmodule

// ===== hdl/sfdp_queue.sv =====
// two-entry request queue between the input side and the datapath
`timescale 1ns / 1ps

module sfdp_queue #(
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output logic [DATA_W-1:0] head_data
);

	logic [DATA_W-1:0] entry_q [2];
	logic              head_q;
	logic              tail_q;
	logic [1:0]        count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_data  = entry_q[head_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= 1'b0;
			tail_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= ~tail_q;
			end
			if (pop) begin
				head_q <= ~head_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[tail_q] <= push_data;
		end
	end

endmodule

// ===== hdl/sfdp_back.sv =====
// datapath: sample store, wet and feedback products, write-back and output register
`timescale 1ns / 1ps

module sfdp_back #(
	parameter int DELAY_DEPTH = sfdp_pkg::DEPTH_DEF,
	parameter int PTR_W       = $clog2(DELAY_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sfdp_pkg::cfg_t    cfg,
	input  logic              q_valid,
	output logic              q_pop,
	input  sfdp_pkg::item_t   q_item,
	input  logic [PTR_W-1:0]  q_wp,
	input  logic [PTR_W-1:0]  q_rd,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata
);

	// both channels share one address, so they share one word
	logic [31:0]             store_mem [DELAY_DEPTH];
	logic [31:0]             rdata_q;

	logic                    s1_valid_q;
	sfdp_pkg::item_t         item_s1;
	logic [PTR_W-1:0]        wp_s1;
	logic                    fwd_s1;
	logic [31:0]             fwd_data_s1;

	logic                    s2_valid_q;
	logic [15:0]             left_s2;
	logic [15:0]             right_s2;
	logic [PTR_W-1:0]        wp_s2;
	logic signed [48:0]      wl_s2;
	logic signed [48:0]      wr_s2;
	logic signed [32:0]      fl_s2;
	logic signed [32:0]      fr_s2;

	logic                    out_valid_q;
	logic [31:0]             out_data_q;

	logic                    s1_adv;
	logic                    s2_adv;
	logic [15:0]             d_l;
	logic [15:0]             d_r;
	logic [31:0]             mem_word;
	logic signed [48:0]      wl_c;
	logic signed [48:0]      wr_c;
	logic signed [32:0]      fl_c;
	logic signed [32:0]      fr_c;
	logic signed [48:0]      wl_rnd;
	logic signed [48:0]      wr_rnd;
	logic signed [32:0]      fl_rnd;
	logic signed [32:0]      fr_rnd;
	logic [15:0]             out_l;
	logic [15:0]             out_r;
	logic [15:0]             st_l;
	logic [15:0]             st_r;

	// one item in the first stage at a time keeps reads behind write-backs
	assign q_pop   = q_valid && !s1_valid_q;
	assign s2_adv  = s2_valid_q && (!out_valid_q || m_tready);
	assign s1_adv  = s1_valid_q && (!s2_valid_q || s2_adv);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_comb begin
		mem_word = fwd_s1 ? fwd_data_s1 : rdata_q;
		case (item_s1.kind)
			sfdp_pkg::SRC_SELF: begin
				d_l = item_s1.left;
				d_r = item_s1.right;
			end
			sfdp_pkg::SRC_STORE: begin
				d_l = mem_word[15:0];
				d_r = mem_word[31:16];
			end
			default: begin
				d_l = '0;
				d_r = '0;
			end
		endcase
		wl_c = $signed(d_l) * $signed({1'b0, cfg.gain_l});
		wr_c = $signed(d_r) * $signed({1'b0, cfg.gain_r});
		fl_c = $signed(d_l) * $signed({1'b0, cfg.fb});
		fr_c = $signed(d_r) * $signed({1'b0, cfg.fb});
	end

	// round half up, then saturate the sums
	always_comb begin
		wl_rnd = wl_s2 + 49'sh0_8000_0000;
		wr_rnd = wr_s2 + 49'sh0_8000_0000;
		fl_rnd = fl_s2 + 33'sh0_0000_8000;
		fr_rnd = fr_s2 + 33'sh0_0000_8000;
		out_l = sfdp_pkg::sat16($signed({{2{left_s2[15]}}, left_s2})
			+ $signed({wl_rnd[48], wl_rnd[48:32]}));
		out_r = sfdp_pkg::sat16($signed({{2{right_s2[15]}}, right_s2})
			+ $signed({wr_rnd[48], wr_rnd[48:32]}));
		st_l = sfdp_pkg::sat16($signed({{2{left_s2[15]}}, left_s2})
			+ $signed({fl_rnd[32], fl_rnd[32:16]}));
		st_r = sfdp_pkg::sat16($signed({{2{right_s2[15]}}, right_s2})
			+ $signed({fr_rnd[32], fr_rnd[32:16]}));
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rdata_q <= store_mem[q_rd];
		end
		if (s2_adv) begin
			store_mem[wp_s2] <= {st_r, st_l};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_valid_q <= 1'b1;
			end else if (s2_adv) begin
				s2_valid_q <= 1'b0;
			end
			if (s2_adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1     <= q_item;
			wp_s1       <= q_wp;
			// write-back still pending for the same entry
			fwd_s1      <= s2_valid_q && (wp_s2 == q_rd);
			fwd_data_s1 <= {st_r, st_l};
		end
		if (s1_adv) begin
			left_s2  <= item_s1.left;
			right_s2 <= item_s1.right;
			wp_s2    <= wp_s1;
			wl_s2    <= wl_c;
			wr_s2    <= wr_c;
			fl_s2    <= fl_c;
			fr_s2    <= fr_c;
		end
		if (s2_adv) begin
			out_data_q <= {out_r, out_l};
		end
	end

endmodule

// ===== hdl/stereo_feedback_delay_pan_top.sv =====
// top level of the stereo feedback delay with panned wet signal
`timescale 1ns / 1ps

// Stereo echo with feedback. The slave stream takes one sample pair per
// request (tdata: left_in, right_in); the master stream returns one pair per
// request (tdata: left_out, right_out). Both channels share one store word.
// Configuration writes (cfg_index, cfg_data) are always taken; a delay length
// write is reduced modulo the store depth, during which s_tready stays low.
// Gain products are registered from the mix and pan registers.
// A request enters a two-entry queue, then passes the store read, the
// products, and rounding with write-back and the output register, each
// registered; a stalled receiver can hold it between them.
// The datapath takes no new pair while the previous one is in its first stage;
// it starts a new store read only once that pair has left, with the pending
// write-back forwarded.
// Reset clears the pointer, all control state and configuration, pan to 0x8000;
// no clearing pass runs, entries not yet written since reset read as zero.
// A stalled receiver holds the output register, then the datapath, then the
// queue; s_tready drops when the queue is full.

module stereo_feedback_delay_pan_top #(
	parameter int DELAY_DEPTH = sfdp_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,   // left_in, right_in
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [31:0]                m_tdata,   // left_out, right_out
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [sfdp_pkg::IDX_W-1:0] cfg_index,
	input  logic [15:0]                cfg_data
);

	localparam int PTR_W  = $clog2(DELAY_DEPTH);
	localparam int ITEM_W = $bits(sfdp_pkg::item_t);
	localparam int QW     = 2 * PTR_W + ITEM_W;

	sfdp_pkg::cfg_t   cfg;
	sfdp_pkg::item_t  f_item;
	sfdp_pkg::item_t  q_item;
	logic             push;
	logic             q_full;
	logic             q_valid;
	logic             q_pop;
	logic [PTR_W-1:0] f_wp;
	logic [PTR_W-1:0] f_rd;
	logic [PTR_W-1:0] q_wp;
	logic [PTR_W-1:0] q_rd;
	logic [QW-1:0]    q_head;

	sfdp_cfg #(
		.DELAY_DEPTH(DELAY_DEPTH)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfdp_front #(
		.DELAY_DEPTH(DELAY_DEPTH),
		.PTR_W      (PTR_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.item     (f_item),
		.wr_ptr   (f_wp),
		.rd_ptr   (f_rd)
	);

	sfdp_queue #(
		.DATA_W(QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({f_wp, f_rd, f_item}),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (q_head)
	);

	assign q_item = sfdp_pkg::item_t'(q_head[ITEM_W-1:0]);
	assign q_rd   = q_head[ITEM_W +: PTR_W];
	assign q_wp   = q_head[ITEM_W + PTR_W +: PTR_W];

	sfdp_back #(
		.DELAY_DEPTH(DELAY_DEPTH),
		.PTR_W      (PTR_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item),
		.q_wp     (q_wp),
		.q_rd     (q_rd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("request pushed into a full queue");

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.busy |-> !s_tready)
		else $error("input taken while delay length is being reduced");

	a_delay_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == sfdp_pkg::REG_DELAY) |=> cfg.busy)
		else $error("delay length write did not start the reduction");

	a_pop_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("datapath popped an empty queue");

endmodule
